>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked every clock outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/btpc_pkg.sv
package btpc_pkg;

	localparam int unsigned CfgIdxW = 3;

	localparam logic [CfgIdxW-1:0] REG_AC1_AC2  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_AC3_AC4  = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_AC5_AC6  = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_B1_B2    = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_MC_MD    = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_OSS      = 3'd5;

	localparam int unsigned InW  = 40;
	localparam int unsigned OutW = 48;

	// Number of stages in each divider
	localparam int unsigned DivStages = 32;

	typedef struct packed {
		logic signed [15:0] ac1;
		logic signed [15:0] ac2;
		logic signed [15:0] ac3;
		logic        [15:0] ac4;
		logic        [15:0] ac5;
		logic        [15:0] ac6;
		logic signed [15:0] b1;
		logic signed [15:0] b2;
		logic signed [15:0] mc;
		logic signed [15:0] md;
		logic        [1:0]  oss;
	} cal_t;

	function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned n);
		logic signed [31:0] s;
		s = signed'(v);
		return 32'(s >>> n);
	endfunction

endpackage

>>> hdl/barometer_temp_pressure_compensation_unit.sv
// Between input accept and output valid lie 2 * 32 divider stages,
// 9 arithmetic stages and one output register.
// Throughput: one reading pair per cycle unless the output stalls; the two pipelined dividers set the depth.
// The whole pipe advances together and holds while the output register is full and stalled.
// Reset: control and valid bits clear asynchronously on arst_n low; calibration
// registers clear to zero. Payload registers are not reset.
module barometer_temp_pressure_compensation_unit (
	input  logic        clk,
	input  logic        arst_n,
	// s_axis_tdata: raw_temp[15:0], raw_pressure[34:16], zero fill [39:35]
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [btpc_pkg::InW-1:0] s_axis_tdata,
	// m_axis_tdata: temperature[15:0], pressure[47:16]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [btpc_pkg::OutW-1:0] m_axis_tdata,
	// m_axis_tuser: divide_error
	output logic        m_axis_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [btpc_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [31:0] cfg_data
);
	import btpc_pkg::*;
	`include "assert_macros.svh"

	cal_t cal_q;
	logic en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_AC1_AC2: begin cal_q.ac1 <= cfg_data[31:16]; cal_q.ac2 <= cfg_data[15:0]; end
				REG_AC3_AC4: begin cal_q.ac3 <= cfg_data[31:16]; cal_q.ac4 <= cfg_data[15:0]; end
				REG_AC5_AC6: begin cal_q.ac5 <= cfg_data[31:16]; cal_q.ac6 <= cfg_data[15:0]; end
				REG_B1_B2:   begin cal_q.b1  <= cfg_data[31:16]; cal_q.b2  <= cfg_data[15:0]; end
				REG_MC_MD:   begin cal_q.mc  <= cfg_data[31:16]; cal_q.md  <= cfg_data[15:0]; end
				REG_OSS:     cal_q.oss <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Pipe advances unless the output holds an untaken result
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// ---------- stage 1: UT - AC6 and multiply by AC5 ----------
	logic        v_s1;
	logic [31:0] x1t_s1;
	logic [18:0] up_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_axis_tvalid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			x1t_s1 <= asr32((32'(s_axis_tdata[15:0]) - 32'(cal_q.ac6)) * 32'(cal_q.ac5), 15);
			up_s1  <= s_axis_tdata[34:16];
		end
	end

	// ---------- stage 2: divisor X1+MD and sign handling ----------
	logic        v_s2;
	logic [31:0] x1t_s2, dnum_s2, dden_s2;
	logic        dneg_s2, dz_s2;
	logic [18:0] up_s2;
	logic [31:0] den_c, num_c;
	assign den_c = x1t_s1 + 32'(cal_q.md);
	assign num_c = 32'(cal_q.mc) << 11;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			x1t_s2  <= x1t_s1;
			up_s2   <= up_s1;
			dz_s2   <= (den_c == '0);
			dneg_s2 <= num_c[31] ^ den_c[31];
			dnum_s2 <= num_c[31] ? (~num_c + 32'd1) : num_c;
			dden_s2 <= den_c[31] ? (~den_c + 32'd1) : den_c;
		end
	end

	// ---------- divider 1: MC<<11 / (X1+MD) ----------
	localparam int unsigned S1W = 32 + 19 + 2;
	logic            dv1_o;
	logic [31:0]     dq1_o;
	logic [S1W-1:0]  ds1_o;
	btpc_divider #(.SideW(S1W)) u_div_t (
		.clk, .arst_n, .en,
		.in_valid(v_s2), .in_num(dnum_s2), .in_den(dden_s2),
		.in_side({x1t_s2, up_s2, dneg_s2, dz_s2}),
		.out_valid(dv1_o), .out_quot(dq1_o), .out_side(ds1_o)
	);

	// ---------- stage 3: B5 and B6 ----------
	logic        v_s3, err_s3;
	logic [31:0] b5_s3, b6_s3;
	logic [18:0] up_s3;
	logic [31:0] x2t_c, b5_c;
	assign x2t_c = ds1_o[1] ? (~dq1_o + 32'd1) : dq1_o;
	assign b5_c  = ds1_o[S1W-1 -: 32] + x2t_c;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= dv1_o;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			err_s3 <= ds1_o[0];
			b5_s3  <= b5_c;
			b6_s3  <= b5_c - 32'd4000;
			up_s3  <= ds1_o[20:2];
		end
	end

	// ---------- stage 4: B6^2, AC2*B6, AC3*B6 ----------
	logic        v_s4, err_s4;
	logic [31:0] b5_s4, b6sq_s4, x2p_s4, x1q_s4;
	logic [18:0] up_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			err_s4  <= err_s3;
			b5_s4   <= b5_s3;
			up_s4   <= up_s3;
			b6sq_s4 <= asr32(b6_s3 * b6_s3, 12);
			x2p_s4  <= asr32(32'(cal_q.ac2) * b6_s3, 11);
			x1q_s4  <= asr32(32'(cal_q.ac3) * b6_s3, 13);
		end
	end

	// ---------- stage 5: B2*B6sq, B1*B6sq ----------
	logic        v_s5, err_s5;
	logic [31:0] b5_s5, x1p_s5, x2p_s5, x1q_s5, x2q_s5;
	logic [18:0] up_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			err_s5 <= err_s4;
			b5_s5  <= b5_s4;
			up_s5  <= up_s4;
			x1p_s5 <= asr32(32'(cal_q.b2) * b6sq_s4, 11);
			x2p_s5 <= x2p_s4;
			x1q_s5 <= x1q_s4;
			x2q_s5 <= asr32(32'(cal_q.b1) * b6sq_s4, 16);
		end
	end

	// ---------- stage 6: B3 and X3 ----------
	logic        v_s6, err_s6;
	logic [31:0] b5_s6, b3_s6, x3_s6;
	logic [18:0] up_s6;
	logic [31:0] x3p_c;
	assign x3p_c = x1p_s5 + x2p_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= v_s5;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			err_s6 <= err_s5;
			b5_s6  <= b5_s5;
			up_s6  <= up_s5;
			b3_s6  <= asr32(((32'(cal_q.ac1) * 32'd4 + x3p_c) << cal_q.oss) + 32'd2, 2);
			x3_s6  <= asr32(x1q_s5 + x2q_s5 + 32'd2, 2);
		end
	end

	// ---------- stage 7: B4 and B7 ----------
	logic        v_s7, err_s7;
	logic [31:0] b5_s7, b4_s7, b7_s7;
	logic [31:0] b4w_c;
	// product wraps at 32 bits before the shift
	assign b4w_c = 32'(cal_q.ac4) * (x3_s6 + 32'd32768);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (en) v_s7 <= v_s6;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			err_s7 <= err_s6;
			b5_s7  <= b5_s6;
			b4_s7  <= b4w_c >> 15;
			b7_s7  <= (32'(up_s6) - b3_s6) * (32'd50000 >> cal_q.oss);
		end
	end

	// ---------- divider 2: B7*2 / B4 or B7 / B4 ----------
	localparam int unsigned S2W = 32 + 2;
	logic            dv2_o;
	logic [31:0]     dq2_o;
	logic [S2W-1:0]  ds2_o;
	logic            big_c, err2_c;
	assign big_c  = b7_s7[31];
	assign err2_c = err_s7 || (b4_s7 == '0);
	btpc_divider #(.SideW(S2W)) u_div_p (
		.clk, .arst_n, .en,
		.in_valid(v_s7), .in_num(big_c ? b7_s7 : (b7_s7 << 1)), .in_den(b4_s7),
		.in_side({b5_s7, big_c, err2_c}),
		.out_valid(dv2_o), .out_quot(dq2_o), .out_side(ds2_o)
	);

	// ---------- stage 8: P and (P>>8)^2 ----------
	logic        v_s8, err_s8;
	logic [31:0] b5_s8, p_s8, sq_s8;
	logic [31:0] p_c, ps_c;
	assign p_c  = ds2_o[1] ? (dq2_o << 1) : dq2_o;
	assign ps_c = asr32(p_c, 8);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else if (en) v_s8 <= dv2_o;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			err_s8 <= ds2_o[0];
			b5_s8  <= ds2_o[S2W-1 -: 32];
			p_s8   <= p_c;
			sq_s8  <= ps_c * ps_c;
		end
	end

	// ---------- stage 9: products with 3038 and -7357 ----------
	logic        v_s9, err_s9;
	logic [31:0] b5_s9, p_s9, x1_s9, x2_s9;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s9 <= 1'b0;
		else if (en) v_s9 <= v_s8;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			err_s9 <= err_s8;
			b5_s9  <= b5_s8;
			p_s9   <= p_s8;
			x1_s9  <= asr32(sq_s8 * 32'd3038, 16);
			x2_s9  <= asr32((~32'd7357 + 32'd1) * p_s8, 16);
		end
	end

	// ---------- output register: final sums, saturation, error forcing ----------
	logic [31:0] pf_c, t_c;
	logic [15:0] ts_c;
	assign pf_c = p_s9 + asr32(x1_s9 + x2_s9 + 32'd3791, 4);
	assign t_c  = asr32(b5_s9 + 32'd8, 4);
	always_comb begin
		if (t_c[31] && (t_c < 32'hFFFF_8000)) ts_c = 16'h8000;
		else if (!t_c[31] && (t_c > 32'h0000_7FFF)) ts_c = 16'h7FFF;
		else ts_c = t_c[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (en) m_axis_tvalid <= v_s9;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tuser <= err_s9;
			m_axis_tdata <= err_s9 ? '0 : {pf_c, ts_c};
		end
	end

	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")
	`ASSERT_IMPL(a_err_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "error result not zero")
	`ASSERT_IMPL(a_ready_en, clk, arst_n, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")
endmodule

>>> hdl/btpc_divider.sv
// Pipelined unsigned 32/32 restoring divider: one quotient bit per stage.
// A side payload travels alongside each request.
module btpc_divider #(
	parameter int unsigned SideW = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [31:0]      in_num,
	input  logic [31:0]      in_den,
	input  logic [SideW-1:0] in_side,
	output logic             out_valid,
	output logic [31:0]      out_quot,
	output logic [SideW-1:0] out_side
);
	import btpc_pkg::*;

	logic                    vld_q  [DivStages];
	logic [31:0]             quo_q  [DivStages];
	logic [SideW-1:0]        side_q [DivStages];
	logic [31:0]             rem_q  [DivStages-1];
	logic [31:0]             den_q  [DivStages-1];

	for (genvar g = 0; g < DivStages; g++) begin : g_stage
		logic             vld_in;
		logic [31:0]      rem_in;
		logic [31:0]      quo_in;
		logic [31:0]      den_in;
		logic [SideW-1:0] side_in;
		logic [32:0]      trial;
		logic [32:0]      shifted;

		if (g == 0) begin : g_head
			assign vld_in  = in_valid;
			assign rem_in  = '0;
			assign quo_in  = in_num;
			assign den_in  = in_den;
			assign side_in = in_side;
		end else begin : g_body
			assign vld_in  = vld_q[g-1];
			assign rem_in  = rem_q[g-1];
			assign quo_in  = quo_q[g-1];
			assign den_in  = den_q[g-1];
			assign side_in = side_q[g-1];
		end

		assign shifted = {rem_in, quo_in[31]};
		assign trial   = shifted - {1'b0, den_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[g] <= 1'b0;
			end else if (en) begin
				vld_q[g] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_q[g]  <= {quo_in[30:0], ~trial[32]};
				side_q[g] <= side_in;
			end
		end

		// the last stage keeps no remainder or divisor
		if (g < DivStages-1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					if (!trial[32]) begin
						rem_q[g] <= trial[31:0];
					end else begin
						rem_q[g] <= shifted[31:0];
					end
					den_q[g] <= den_in;
				end
			end
		end
	end

	assign out_valid = vld_q[DivStages-1];
	assign out_quot  = quo_q[DivStages-1];
	assign out_side  = side_q[DivStages-1];
endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import btpc_pkg::*;

	localparam int PIPE_LAT = 2 * DivStages + 16;

	typedef struct packed {
		logic        div_err;
		logic [31:0] press;
		logic [15:0] temp;
	} reading_t;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [InW-1:0]    s_axis_tdata;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [OutW-1:0]   m_axis_tdata;
	logic              m_axis_tuser;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CfgIdxW-1:0] cfg_index;
	logic [31:0]       cfg_data;

	logic [31:0] cal_regs [0:4];
	logic [1:0]  oss_reg;
	reading_t    pending_readings [$];
	int          mismatch_count;
	int          hold_off_cycles;
	bit          stall_random;

	barometer_temp_pressure_compensation_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] shr_arith(input logic [31:0] v, input int n);
		logic signed [31:0] s;
		s = v;
		return s >>> n;
	endfunction

	function automatic logic [31:0] div_trunc(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] ma, mb, q;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		return (a[31] != b[31]) ? -q : q;
	endfunction

	function automatic reading_t compensate(input logic [15:0] ut, input logic [18:0] up);
		logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
		logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, b6sq, p, t;
		reading_t r;
		ac1 = sx16(cal_regs[0][31:16]); ac2 = sx16(cal_regs[0][15:0]);
		ac3 = sx16(cal_regs[1][31:16]); ac4 = {16'd0, cal_regs[1][15:0]};
		ac5 = {16'd0, cal_regs[2][31:16]}; ac6 = {16'd0, cal_regs[2][15:0]};
		b1 = sx16(cal_regs[3][31:16]); b2 = sx16(cal_regs[3][15:0]);
		mc = sx16(cal_regs[4][31:16]); md = sx16(cal_regs[4][15:0]);
		r = '{div_err: 1'b1, press: 32'd0, temp: 16'd0};
		x1 = shr_arith(({16'd0, ut} - ac6) * ac5, 15);
		if (x1 + md == 0) return r;
		x2 = div_trunc(mc << 11, x1 + md);
		b5 = x1 + x2;
		t = shr_arith(b5 + 8, 4);
		b6 = b5 - 32'd4000;
		b6sq = shr_arith(b6 * b6, 12);
		x1 = shr_arith(b2 * b6sq, 11);
		x2 = shr_arith(ac2 * b6, 11);
		x3 = x1 + x2;
		b3 = shr_arith(((ac1 * 4 + x3) << oss_reg) + 2, 2);
		x1 = shr_arith(ac3 * b6, 13);
		x2 = shr_arith(b1 * b6sq, 16);
		x3 = shr_arith(x1 + x2 + 2, 2);
		b4 = (ac4 * (x3 + 32'd32768)) >> 15;
		if (b4 == 0) return r;
		b7 = ({13'd0, up} - b3) * (32'd50000 >> oss_reg);
		if (b7 < 32'h8000_0000) p = (b7 * 2) / b4;
		else p = (b7 / b4) * 2;
		x1 = shr_arith(p, 8);
		x1 = x1 * x1;
		x1 = shr_arith(x1 * 32'd3038, 16);
		x2 = shr_arith(-32'd7357 * p, 16);
		p = p + shr_arith(x1 + x2 + 32'd3791, 4);
		if (t[31]) begin
			if (t < 32'hFFFF_8000) t = 32'hFFFF_8000;
		end else if (t > 32'h7FFF) begin
			t = 32'h7FFF;
		end
		r = '{div_err: 1'b0, press: p, temp: t[15:0]};
		return r;
	endfunction

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx <= REG_MC_MD) cal_regs[idx] = val;
		else if (idx == REG_OSS) oss_reg = val[1:0];
	endtask

	task automatic wait_drained;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (PIPE_LAT) @(posedge clk);
	endtask

	task automatic set_cal(input logic [31:0] r0, r1, r2, r3, r4, input logic [1:0] oss);
		wait_drained();
		write_reg(REG_AC1_AC2, r0);
		write_reg(REG_AC3_AC4, r1);
		write_reg(REG_AC5_AC6, r2);
		write_reg(REG_B1_B2, r3);
		write_reg(REG_MC_MD, r4);
		write_reg(REG_OSS, {30'd0, oss});
	endtask

	// send one request; bursts with random gaps when gaps is set
	task automatic send_reading(input logic [15:0] ut, input logic [18:0] up, input bit gaps);
		if (gaps && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'd0, up, ut};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_readings.push_back(compensate(ut, up));
	endtask

	task automatic idle_sender;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic typical_cal;
		set_cal({16'd408, 16'hFFBC}, {16'hC3C5, 16'd32741}, {16'd32757, 16'd23153},
			{16'd6190, 16'd4}, {16'h D4BD, 16'd2868}, 2'd0);
	endtask

	task automatic test_directed;
		typical_cal();
		send_reading(16'd27898, 19'd23843, 0);
		send_reading(16'd0, 19'd0, 0);
		send_reading(16'hFFFF, 19'h7FFFF, 0);
		send_reading(16'h5555, 19'h2AAAA, 0);
		send_reading(16'hAAAA, 19'h55555, 0);
		idle_sender();
		// zero first divisor: X1 is zero with AC5 = 0 and MD = 0
		set_cal({16'd408, 16'hFFBC}, {16'hC3C5, 16'd32741}, {16'd0, 16'd23153},
			{16'd6190, 16'd4}, {16'h D4BD, 16'd0}, 2'd1);
		send_reading(16'd1234, 19'd5000, 0);
		idle_sender();
		// zero B4: AC4 = 0
		set_cal({16'd408, 16'hFFBC}, {16'hC3C5, 16'd0}, {16'd32757, 16'd23153},
			{16'd6190, 16'd4}, {16'h D4BD, 16'd2868}, 2'd2);
		send_reading(16'd27898, 19'd23843, 0);
		idle_sender();
		// extremes: saturation, wrapping, large B7, quotient of min by -1
		set_cal(32'h8000_7FFF, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'h8000_8000,
			32'h8000_0001, 2'd3);
		send_reading(16'hFFFF, 19'd0, 0);
		send_reading(16'd0, 19'h7FFFF, 0);
		idle_sender();
		set_cal(32'hFFFF_FFFF, 32'h8000_0001, 32'hFFFF_FFFF, 32'h7FFF_7FFF,
			32'h7FFF_FFFF, 2'd3);
		send_reading(16'd0, 19'd0, 0);
		send_reading(16'hFFFF, 19'h7FFFF, 0);
		send_reading(16'd100, 19'd300000, 0);
		idle_sender();
		set_cal(32'h0001_0001, 32'h0001_0001, 32'h0001_0001, 32'h0001_0001,
			32'h0001_0001, 2'd0);
		send_reading(16'd1, 19'd1, 0);
		idle_sender();
		wait_drained();
		write_reg(3'd7, 32'hDEAD_BEEF);
		send_reading(16'd1, 19'd2, 0);
		idle_sender();
	endtask

	task automatic test_random(input int n_items, input bit near_typical);
		logic [31:0] r [0:4];
		for (int ph = 0; ph < 7; ph++) begin
			for (int k = 0; k < 5; k++) r[k] = $urandom;
			if (near_typical) begin
				r[1][15:0] = 16'(32000 + $urandom_range(0, 1500));
				r[2] = {16'(30000 + $urandom_range(0, 5000)), 16'(20000 + $urandom_range(0, 6000))};
				r[4] = {16'(-$urandom_range(8000, 14000)), 16'($urandom_range(1000, 4000))};
			end
			set_cal(r[0], r[1], r[2], r[3], r[4], 2'($urandom_range(0, 3)));
			for (int i = 0; i < n_items / 7; i++) begin
				if (near_typical)
					send_reading(16'($urandom_range(20000, 35000)),
						19'($urandom_range(10000, 350000)), 1);
				else
					send_reading(16'($urandom), 19'($urandom), 1);
			end
			idle_sender();
		end
	endtask

	task automatic test_backpressure;
		typical_cal();
		hold_off_cycles = 200;
		for (int i = 0; i < 150; i++)
			send_reading(16'($urandom), 19'($urandom), 0);
		idle_sender();
	endtask

	// receiver stall pattern, with a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			m_axis_tready <= 1'b0;
		end else if (stall_random) begin
			m_axis_tready <= ($urandom_range(0, 3) != 0);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_readings.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result tdata=%h tuser=%b", m_axis_tdata, m_axis_tuser);
			end else begin
				reading_t e;
				e = pending_readings.pop_front();
				if (m_axis_tdata[15:0] !== e.temp || m_axis_tdata[47:16] !== e.press
						|| m_axis_tuser !== e.div_err) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: exp temp=%0d press=%0d err=%b got temp=%0d press=%0d err=%b",
							$signed(e.temp), $signed(e.press), e.div_err,
							$signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[47:16]),
							m_axis_tuser);
				end
			end
		end
	end

	initial begin
		#4000000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatch_count = 0;
		hold_off_cycles = 0;
		stall_random = 1'b0;
		oss_reg = '0;
		for (int k = 0; k < 5; k++) cal_regs[k] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		stall_random = 1'b1;
		test_random(350, 1);
		test_random(200, 0);
		test_backpressure();
		stall_random = 1'b0;
		wait_drained();
		if (mismatch_count == 0 && pending_readings.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
